[rtl/core/slist_pkg.sv]
// Package for the sorted insertion list: operation and status codes and
// the request and result payload types.
// No dependencies.
package slist_pkg;

  localparam int VALUE_BITS = 32;
  localparam int POS_BITS   = 6;
  localparam int CAPACITY   = 32;

  typedef enum logic [1:0] {
    OP_INS_POS = 2'd0,
    OP_INS_ORD = 2'd1,
    OP_READ    = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_RSVD   = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]                   operation;
    logic signed [VALUE_BITS-1:0] value;
    logic [POS_BITS-1:0]          position;
  } slist_req_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] read_value;
    logic [1:0]                   status;
    logic [POS_BITS-1:0]          count;
  } slist_rsp_t;

  // broadcast from the control to every cell of the row
  typedef struct packed {
    logic                         ins_pos;
    logic                         ins_ord;
    logic                         rd_en;
    logic signed [VALUE_BITS-1:0] value;
  } slist_cmd_t;

endpackage

[rtl/core/slist_cell.sv]
// One storage cell of the sorted insertion list row: holds one entry,
// compares it with the request value and shifts from its left neighbor.
// Depends on slist_pkg.
module slist_cell import slist_pkg::*; #(
  parameter int IDX_W = 5,
  parameter int CNT_W = 6,
  parameter int IDX   = 0
) (
  input  logic                         clk,
  input  slist_cmd_t                   cmd_i,
  input  logic [CNT_W-1:0]             count_i,
  input  logic [IDX_W-1:0]             slot_i,
  input  logic signed [VALUE_BITS-1:0] left_i,
  input  logic                         less_i,
  input  logic [VALUE_BITS-1:0]        rd_i,
  output logic signed [VALUE_BITS-1:0] entry_o,
  output logic                         less_o,
  output logic [VALUE_BITS-1:0]        rd_o
);

  logic signed [VALUE_BITS-1:0] entry_r;
  logic signed [VALUE_BITS-1:0] entry_nxt;
  logic                         occupied;
  logic                         lt;
  logic                         at_slot;
  logic                         take_new;
  logic                         shift;

  assign occupied = CNT_W'(IDX) < count_i;
  assign lt       = occupied && ($signed(entry_r) < $signed(cmd_i.value));
  assign less_o   = less_i && lt;
  assign at_slot  = slot_i == IDX_W'(IDX);

  // decide between keeping, taking the new value, or taking the left entry
  always_comb begin
    take_new = 1'b0;
    shift    = 1'b0;
    priority if (cmd_i.ins_ord) begin
      take_new = less_i && !lt;
      shift    = !less_i;
    end else if (cmd_i.ins_pos) begin
      take_new = at_slot;
      shift    = IDX_W'(IDX) > slot_i;
    end else begin
      take_new = 1'b0;
      shift    = 1'b0;
    end
  end

  always_comb begin
    priority if (take_new) begin
      entry_nxt = cmd_i.value;
    end else if (shift) begin
      entry_nxt = left_i;
    end else begin
      entry_nxt = entry_r;
    end
  end

  // storage holds no reset; only entries below the count are ever read
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // merge this entry onto the read bus when addressed
  assign rd_o    = rd_i | ((cmd_i.rd_en && at_slot) ? entry_r : '0);
  assign entry_o = entry_r;

endmodule

[rtl/core/sorted_list_insert_get.sv]
// Sorted insertion list: one request per cycle sustained unless out_stall holds
// a waiting result; every request is decoded, compared and shifted across the
// whole row of cells combinationally, then held in the output register.
// The next request is taken while a result waits only if out_stall is low.
// Reset (rst_n low, synchronous) clears the count and the output valid;
// entry storage is not cleared.
module sorted_list_insert_get import slist_pkg::*; #(
  parameter int CAPACITY = slist_pkg::CAPACITY
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  slist_req_t in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output slist_rsp_t out_data
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > POS_BITS) ? CNT_W : POS_BITS) + 1;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  slist_rsp_t        out_data_r;
  slist_rsp_t        out_data_nxt;

  logic              in_acc;
  op_t               op;
  logic [CMP_W-1:0]  pos_x;
  logic [CMP_W-1:0]  cnt_x;
  logic              full;
  logic              empty;
  logic              pos_ins_ok;
  logic              pos_rd_ok;
  logic [IDX_W-1:0]  slot;
  slist_cmd_t        cmd;
  status_t           status;

  logic signed [VALUE_BITS-1:0] entry_w [CAPACITY];
  logic                         less_w  [CAPACITY+1];
  logic [VALUE_BITS-1:0]        rd_w    [CAPACITY+1];

  // handshake: take a request unless a result is stuck in the output register
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // decode the request
  assign op         = op_t'(in_data.operation);
  assign pos_x      = CMP_W'(in_data.position);
  assign cnt_x      = CMP_W'(count_r);
  assign full       = cnt_x >= CMP_W'(CAPACITY);
  assign empty      = count_r == '0;
  assign pos_ins_ok = empty || ((pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1)));
  assign pos_rd_ok  = (pos_x != '0) && (pos_x <= cnt_x);
  assign slot       = (empty && (op == OP_INS_POS)) ? '0 : IDX_W'(pos_x - CMP_W'(1));

  always_comb begin
    cmd       = '0;
    cmd.value = in_data.value;
    status    = ST_OK;
    unique case (op)
      OP_INS_POS: begin
        if (full) begin
          status = ST_FULL;
        end else if (!pos_ins_ok) begin
          status = ST_BADPOS;
        end else begin
          cmd.ins_pos = in_acc;
        end
      end
      OP_INS_ORD: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          cmd.ins_ord = in_acc;
        end
      end
      OP_READ: begin
        if (pos_rd_ok) begin
          cmd.rd_en = in_acc;
        end else begin
          status = ST_BADPOS;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  // row of cells; the less-than prefix and the read bus ripple through it
  assign less_w[0] = 1'b1;
  assign rd_w[0]   = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VALUE_BITS-1:0] left;
    if (i == 0) begin : g_head
      assign left = cmd.value;
    end else begin : g_body
      assign left = entry_w[i-1];
    end
    slist_cell #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk     (clk),
      .cmd_i   (cmd),
      .count_i (count_r),
      .slot_i  (slot),
      .left_i  (left),
      .less_i  (less_w[i]),
      .rd_i    (rd_w[i]),
      .entry_o (entry_w[i]),
      .less_o  (less_w[i+1]),
      .rd_o    (rd_w[i+1])
    );
  end

  // advance the count on a successful insert
  assign count_nxt = (cmd.ins_pos || cmd.ins_ord) ? count_r + CNT_W'(1) : count_r;

  // build the result
  always_comb begin
    out_data_nxt            = out_data_r;
    out_data_nxt.read_value = rd_w[CAPACITY];
    out_data_nxt.status     = status;
    out_data_nxt.count      = POS_BITS'(count_nxt);
    if (!in_acc) begin
      out_data_nxt = out_data_r;
    end
  end

  // output valid: set on a request, drop once taken
  always_comb begin
    priority if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CMP_W'(CAPACITY))
    else $error("count exceeds capacity");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("no result after accepted request");

  a_read_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (op == OP_READ) |=> $stable(count_r))
    else $error("read changed the count");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status == ST_FULL) |->
      CMP_W'(count_r) == CMP_W'(CAPACITY))
    else $error("full status while list not full");
`endif

endmodule

[bench/slist_check.sv]
// Result checker for the sorted insertion list: watches the request and
// result channels, predicts each result from its own copy of the list and
// compares field by field. Depends on slist_pkg.
module slist_check import slist_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  slist_req_t in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  slist_rsp_t out_data,
  output int         mismatches,
  output int         results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // list contents as the block should hold them, head first
  logic signed [VALUE_BITS-1:0] held_list[$];
  // results owed by the block, oldest first
  slist_rsp_t                   owed_results[$];

  initial begin
    mismatches  = 0;
    results_due = 0;
  end

  // Apply one request to the list copy and return the result it yields.
  function automatic slist_rsp_t apply_request(slist_req_t req);
    slist_rsp_t                   rsp;
    logic signed [VALUE_BITS-1:0] val;
    int                           pos;
    int                           slot;
    rsp        = '0;
    rsp.status = ST_OK;
    val        = $signed(req.value);
    pos        = int'(req.position);
    case (op_t'(req.operation))
      OP_INS_POS: begin
        // fullness wins over a bad position; an empty list takes any position
        if (held_list.size() >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else if (held_list.size() == 0) begin
          held_list.push_back(val);
        end else if (pos >= 1 && pos <= held_list.size() + 1) begin
          held_list.insert(pos - 1, val);
        end else begin
          rsp.status = ST_BADPOS;
        end
      end
      OP_INS_ORD: begin
        if (held_list.size() >= CAPACITY) begin
          rsp.status = ST_FULL;
        end else begin
          // place before the first element not less than the new value
          slot = 0;
          while (slot < held_list.size() && held_list[slot] < val) slot++;
          held_list.insert(slot, val);
        end
      end
      OP_READ: begin
        if (pos >= 1 && pos <= held_list.size()) begin
          rsp.read_value = held_list[pos - 1];
        end else begin
          rsp.status = ST_BADPOS;
        end
      end
      default: ;
    endcase
    rsp.count = POS_BITS'(held_list.size());
    return rsp;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Retire a result before recording a new request: as the result is
  // registered, a result never belongs to the request taken at the same edge.
  always @(posedge clk) begin
    slist_rsp_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result with none owed (value %0d status %0d count %0d)",
                                    out_data.read_value, out_data.status, out_data.count));
        end else begin
          want = owed_results.pop_front();
          if (out_data.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %0d, expected %0d",
                                      out_data.read_value, want.read_value));
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_data.status, want.status));
          if (out_data.count !== want.count)
            report_mismatch($sformatf("count %0d, expected %0d",
                                      out_data.count, want.count));
        end
      end
      if (in_valid && !in_stall) owed_results.push_back(apply_request(in_data));
      results_due = owed_results.size();
    end
  end

endmodule

[bench/tb.sv]
// Top of the sorted insertion list bench: clock, reset, request stimulus and
// receiver stalls, and the verdict. Depends on slist_pkg, the block and
// slist_check.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import slist_pkg::*;

  localparam int ITEMS_PER_PHASE = 175;
  localparam int VAL_MAX         = 32'sh7fff_ffff;
  localparam int VAL_MIN         = 32'sh8000_0000;

  logic       clk       = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  slist_req_t in_data;
  logic       out_valid;
  logic       out_stall = 1'b0;
  slist_rsp_t out_data;
  int         mismatches;
  int         results_due;
  int         gap_pct   = 0;
  int         stall_pct = 0;

  sorted_list_insert_get u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  slist_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .mismatches (mismatches),
    .results_due(results_due)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // stall the result channel at the rate of the current phase
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic slist_req_t pack_request(op_t op, int val, int pos);
    slist_req_t req;
    req.operation = op;
    req.value     = val;
    req.position  = POS_BITS'(pos);
    return req;
  endfunction

  // Mostly reads, enough inserts to fill the list partway through the run;
  // a share of values come from a narrow pool so equal values meet.
  function automatic slist_req_t random_request();
    slist_req_t req;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 8)       req.operation = OP_INS_POS;
    else if (pick < 16) req.operation = OP_INS_ORD;
    else if (pick < 96) req.operation = OP_READ;
    else                req.operation = OP_NOP;
    case ($urandom_range(7))
      0:       req.value = $urandom_range(1) ? VAL_MAX : VAL_MIN;
      1, 2:    req.value = int'($urandom_range(16)) - 8;
      default: req.value = $urandom;
    endcase
    if ($urandom_range(7) == 0) req.position = POS_BITS'($urandom_range(63));
    else                        req.position = POS_BITS'($urandom_range(34));
    return req;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(slist_req_t req);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Hold off new requests until every owed result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (results_due == 0);
    @(negedge clk);
  endtask

  initial begin
    int gap_plan[4]   = '{0, 75, 0, 31};
    int stall_plan[4] = '{0, 0, 75, 31};
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reads of an empty list, then a positional insert at a bad position,
    // which an empty list still takes
    send_request(pack_request(OP_READ, 0, 1));
    send_request(pack_request(OP_READ, 0, 0));
    send_request(pack_request(OP_INS_POS, 100, 0));
    // ordered inserts: append past every element, middle, equal value, head
    send_request(pack_request(OP_INS_ORD, 200, 0));
    send_request(pack_request(OP_INS_ORD, 150, 63));
    send_request(pack_request(OP_INS_ORD, 100, 0));
    send_request(pack_request(OP_INS_ORD, VAL_MIN, 0));
    // positional inserts: position zero, one past the append slot, top code
    send_request(pack_request(OP_INS_POS, 7, 0));
    send_request(pack_request(OP_INS_POS, 7, 7));
    send_request(pack_request(OP_INS_POS, 7, 63));
    // positional inserts: append, head, middle
    send_request(pack_request(OP_INS_POS, VAL_MAX, 6));
    send_request(pack_request(OP_INS_POS, 0, 1));
    send_request(pack_request(OP_INS_POS, -1, 3));
    // reads at head, tail, just past the tail, zero and top code
    send_request(pack_request(OP_READ, 0, 1));
    send_request(pack_request(OP_READ, 0, 8));
    send_request(pack_request(OP_READ, 0, 9));
    send_request(pack_request(OP_READ, 0, 0));
    send_request(pack_request(OP_READ, VAL_MAX, 63));
    send_request(pack_request(OP_NOP, VAL_MIN, 63));
    drain_results();

    // random requests under each idling pattern, draining between phases
    for (int phase = 0; phase < 4; phase++) begin
      gap_pct   = gap_plan[phase];
      stall_pct = stall_plan[phase];
      repeat (ITEMS_PER_PHASE) send_request(random_request());
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // end a hung run
  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/slist_pkg.sv
rtl/core/slist_cell.sv
rtl/core/sorted_list_insert_get.sv
bench/slist_check.sv
bench/tb.sv
